// ===== hw/rtl/rapq_pkg.sv =====
// shared types and constants of the range add / point query tree
// depends on nothing
package rapq_pkg;

  localparam int LOG_SIZE = 10;
  localparam int LEVELS = LOG_SIZE + 1;
  localparam int CELLS = 1 << LOG_SIZE;
  localparam int FW = 10;
  localparam int IW = ((LOG_SIZE > FW) ? LOG_SIZE : FW) + 3;
  localparam int LVW = $clog2(LOG_SIZE + 2);
  localparam int CW = LOG_SIZE + 1;

  typedef struct packed {
    logic func;
    logic [IW-1:0] lo;
    logic [IW-1:0] hi1;
    logic [31:0] amt;
    logic [IW-1:0] idx;
    logic idx_ok;
    logic [31:0] sum;
  } item_t;

  typedef struct packed {
    logic valid;
    item_t item;
  } chain_t;

  typedef struct packed {
    logic we;
    logic [LOG_SIZE-1:0] waddr;
    logic [31:0] wdata;
    logic [LOG_SIZE-1:0] raddr;
  } ram_ctrl_t;

endpackage

// ===== hw/rtl/rapq_ram.sv =====
// generic single write, single read ram with registered read data
// depends on nothing
module rapq_ram #(
  parameter int WIDTH = 32,
  parameter int AW = 1
) (
  input  logic clk,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rapq_cell.sv =====
// one tree level: read-modify-write of up to two tags or one tag read for a query
// depends on rapq_pkg
module rapq_cell (
  input  logic clk,
  input  logic rst,
  input  logic [rapq_pkg::LVW-1:0] level,
  input  rapq_pkg::chain_t chain_in,
  input  logic [31:0] rdata,
  output rapq_pkg::ram_ctrl_t ram,
  output rapq_pkg::chain_t chain_out
);

  typedef enum logic [1:0] {IDLE, PH1, PH2} ph_t;

  localparam logic [rapq_pkg::IW-1:0] ONE = rapq_pkg::IW'(1);

  ph_t ph;
  rapq_pkg::item_t item;
  logic [rapq_pkg::LOG_SIZE-1:0] addr_b;
  logic [rapq_pkg::LOG_SIZE-1:0] ram_waddr_q;
  logic en_a, en_b;

  logic [rapq_pkg::LVW-1:0] s, s1;
  logic [rapq_pkg::IW-1:0] lo, hi1, m, jl, jr1, jr, pl, pr, qi;
  logic covl, covr, pcl, pcr, maxl, maxr, add;
  logic [rapq_pkg::LOG_SIZE-1:0] addr_a_c, addr_b_c;

  always_comb begin
    s = rapq_pkg::LVW'(rapq_pkg::LOG_SIZE) - level;
    s1 = s + rapq_pkg::LVW'(1);
    lo = chain_in.item.lo;
    hi1 = chain_in.item.hi1;
    m = (ONE << s) - ONE;
    jl = (lo + m) >> s;
    jr1 = hi1 >> s;
    jr = jr1 - ONE;
    pl = jl >> 1;
    pr = jr >> 1;
    qi = chain_in.item.idx >> s;
    covl = ((jl + ONE) << s) <= hi1;
    covr = (jr1 != '0) && ((jr << s) >= lo);
    pcl = (level != '0) && ((pl << s1) >= lo) && (((pl + ONE) << s1) <= hi1);
    pcr = (level != '0) && ((pr << s1) >= lo) && (((pr + ONE) << s1) <= hi1);
    add = !chain_in.item.func;
    maxl = add && covl && !pcl;
    maxr = add && covr && !pcr && !(maxl && (jl == jr));
    if (add) begin
      addr_a_c = jl[rapq_pkg::LOG_SIZE-1:0];
    end else begin
      addr_a_c = qi[rapq_pkg::LOG_SIZE-1:0];
    end
    addr_b_c = jr[rapq_pkg::LOG_SIZE-1:0];
  end

  always_comb begin
    ram.we = 1'b0;
    ram.waddr = ram_waddr_q;
    ram.wdata = rdata + item.amt;
    ram.raddr = addr_a_c;
    case (ph)
      PH1: begin
        ram.we = en_a;
        ram.raddr = addr_b;
      end
      PH2: begin
        ram.we = en_b;
        ram.waddr = addr_b;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= IDLE;
      chain_out.valid <= 1'b0;
    end else begin
      chain_out.valid <= 1'b0;
      case (ph)
        IDLE: begin
          if (chain_in.valid) begin
            item <= chain_in.item;
            ram_waddr_q <= addr_a_c;
            addr_b <= addr_b_c;
            en_a <= maxl;
            en_b <= maxr;
            ph <= PH1;
          end
        end
        PH1: begin
          if (item.func && item.idx_ok) begin
            item.sum <= item.sum + rdata;
          end
          ph <= PH2;
        end
        PH2: begin
          chain_out.valid <= 1'b1;
          chain_out.item <= item;
          ph <= IDLE;
        end
        default: begin
          ph <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/range_add_point_query_tree_core.sv =====
// top level: chain of per-level cells, their tag rams and the beat control
// depends on rapq_pkg, rapq_cell, rapq_ram
// One item is in flight at a time. It walks the chain of cells, one cell per
// tree level (LOG_SIZE+1 cells), and each cell reads its level ram, then
// writes up to two tags, so the next input beat is taken only after the item
// has left the last cell, and a query result beat is registered from the item
// as it leaves the last cell. A range add gives no result beat; a point query
// gives one. A waiting result does not hold off the next input beat; only a
// second query that finishes while the first result still waits holds the
// input until that result is taken. After reset a clearing pass zeroes all
// tag rams, with in_ready low.
module range_add_point_query_tree_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic func,
  input  logic [9:0] range_low,
  input  logic [9:0] range_high,
  input  logic signed [31:0] add_amount,
  input  logic [9:0] point_index,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] cell_value
);

  typedef enum logic [1:0] {CLEAR, IDLE, BUSY, HOLD} state_t;

  localparam int L = rapq_pkg::LEVELS;

  state_t state;
  logic [rapq_pkg::CW-1:0] clr_cnt;
  rapq_pkg::chain_t chain [L+1];
  rapq_pkg::ram_ctrl_t ctrl [L];
  logic [31:0] rdata [L];
  logic [rapq_pkg::IW-1:0] hi_ext, hic;

  always_comb begin
    hi_ext = rapq_pkg::IW'(range_high);
    hic = (hi_ext > rapq_pkg::IW'(rapq_pkg::CELLS - 1)) ?
          rapq_pkg::IW'(rapq_pkg::CELLS - 1) : hi_ext;
    chain[0].valid = in_valid && in_ready;
    chain[0].item.func = func;
    chain[0].item.lo = rapq_pkg::IW'(range_low);
    chain[0].item.hi1 = hic + rapq_pkg::IW'(1);
    chain[0].item.amt = add_amount;
    chain[0].item.idx = rapq_pkg::IW'(point_index);
    chain[0].item.idx_ok = rapq_pkg::IW'(point_index) < rapq_pkg::IW'(rapq_pkg::CELLS);
    chain[0].item.sum = '0;
  end

  assign in_ready = (state == IDLE);

  for (genvar d = 0; d < L; d++) begin : g_lvl
    localparam int AW = (d == 0) ? 1 : d;
    logic we;
    logic [AW-1:0] waddr;
    logic [31:0] wdata;

    rapq_cell u_cell (
      .clk(clk),
      .rst(rst),
      .level(rapq_pkg::LVW'(d)),
      .chain_in(chain[d]),
      .rdata(rdata[d]),
      .ram(ctrl[d]),
      .chain_out(chain[d+1])
    );

    always_comb begin
      if (state == CLEAR) begin
        we = 1'b1;
        waddr = clr_cnt[AW-1:0];
        wdata = '0;
      end else begin
        we = ctrl[d].we;
        waddr = ctrl[d].waddr[AW-1:0];
        wdata = ctrl[d].wdata;
      end
    end

    rapq_ram #(.WIDTH(32), .AW(AW)) u_ram (
      .clk(clk),
      .we(we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(ctrl[d].raddr[AW-1:0]),
      .rdata(rdata[d])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        CLEAR: begin
          clr_cnt <= clr_cnt + rapq_pkg::CW'(1);
          if (clr_cnt == rapq_pkg::CW'(rapq_pkg::CELLS - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (in_valid) begin
            state <= BUSY;
          end
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        BUSY: begin
          if (chain[L].valid && chain[L].item.func) begin
            if (!out_valid || out_ready) begin
              out_valid <= 1'b1;
              cell_value <= chain[L].item.sum;
              state <= IDLE;
            end else begin
              state <= HOLD;
            end
          end else begin
            if (out_ready) begin
              out_valid <= 1'b0;
            end
            if (chain[L].valid) begin
              state <= IDLE;
            end
          end
        end
        HOLD: begin
          // last cell keeps its item until a new one reaches the end of the chain
          if (out_ready) begin
            cell_value <= chain[L].item.sum;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input beat taken while an item is in flight");
  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    chain[L].valid |-> (state == BUSY))
    else $error("chain finished outside busy");
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == CLEAR) |-> (!out_valid && !in_ready))
    else $error("activity during clearing pass");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(cell_value)))
    else $error("result beat dropped or changed");
`endif

endmodule
